// File: rtl/bre_pkg.sv
// ----------------------------------------------------------------------------
// bre_pkg - ballistic rate evaluator shared definitions
// Register indexes, angle constants, CORDIC table and saturating helpers.
// ----------------------------------------------------------------------------
package bre_pkg;

  localparam int CORDIC_STEPS = 30;
  localparam int ANG_W        = 34;
  localparam int MUL_LAT      = 5;
  localparam int DIV_STEPS    = 96;
  localparam int DIV_LAT      = DIV_STEPS + 3;

  localparam logic signed [ANG_W-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [ANG_W-1:0] TWO_PI_Q30  = 34'sd6746518852;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [ANG_W-1:0] GAIN_Q30    = 34'sd652032874;

  localparam logic [2:0] REG_THRUST_AXIAL  = 3'd0;
  localparam logic [2:0] REG_THRUST_NORMAL = 3'd1;
  localparam logic [2:0] REG_DRAG_FACTOR   = 3'd2;
  localparam logic [2:0] REG_LIFT_FACTOR   = 3'd3;
  localparam logic [2:0] REG_GRAVITY       = 3'd4;
  localparam logic [2:0] REG_PLANET_RADIUS = 3'd5;

  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};
  localparam logic signed [47:0] S48_MAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] S48_MIN = {1'b1, {47{1'b0}}};

  typedef struct packed {
    logic              sat;
    logic signed [63:0] val;
  } sat64_t;

  typedef struct packed {
    logic              sat;
    logic signed [47:0] val;
  } sat48_t;

  function automatic logic signed [ANG_W-1:0] atan_q30(input int i);
    logic signed [ANG_W-1:0] r;
    case (i)
      0:  r = 34'sd843314857;
      1:  r = 34'sd497837829;
      2:  r = 34'sd263043837;
      3:  r = 34'sd133525159;
      4:  r = 34'sd67021687;
      5:  r = 34'sd33543516;
      6:  r = 34'sd16775851;
      7:  r = 34'sd8388437;
      8:  r = 34'sd4194283;
      9:  r = 34'sd2097149;
      default: r = (i < CORDIC_STEPS) ? (34'sd1 <<< (30 - i)) : 34'sd0;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] a);
    return a[63] ? 64'(64'd0 - a) : 64'(a);
  endfunction

  function automatic sat64_t from_mag(input logic neg, input logic [127:0] m);
    sat64_t r;
    if (neg) begin
      r.sat = (|m[127:64]) || (m[63:0] > 64'h8000_0000_0000_0000);
      r.val = r.sat ? S64_MIN : 64'(64'd0 - m[63:0]);
    end else begin
      r.sat = |m[127:63];
      r.val = r.sat ? S64_MAX : $signed(m[63:0]);
    end
    return r;
  endfunction

  function automatic sat64_t sat_add(input logic signed [63:0] a,
                                     input logic signed [63:0] b);
    logic [64:0] s;
    sat64_t r;
    s = {a[63], a} + {b[63], b};
    r.sat = s[64] ^ s[63];
    r.val = r.sat ? (s[64] ? S64_MIN : S64_MAX) : $signed(s[63:0]);
    return r;
  endfunction

  function automatic sat64_t sat_sub(input logic signed [63:0] a,
                                     input logic signed [63:0] b);
    logic [64:0] s;
    sat64_t r;
    s = {a[63], a} - {b[63], b};
    r.sat = s[64] ^ s[63];
    r.val = r.sat ? (s[64] ? S64_MIN : S64_MAX) : $signed(s[63:0]);
    return r;
  endfunction

  function automatic sat48_t clamp48(input logic signed [63:0] a);
    sat48_t r;
    r.sat = !((&a[63:47]) || !(|a[63:47]));
    r.val = r.sat ? (a[63] ? S48_MIN : S48_MAX) : $signed(a[47:0]);
    return r;
  endfunction

endpackage

// File: rtl/bre_dly.sv
// ----------------------------------------------------------------------------
// bre_dly - stallable delay line
// Carries side data alongside the arithmetic units, N stages deep.
// ----------------------------------------------------------------------------
module bre_dly #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr [0:N-1];

  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= d;
      for (int i = 1; i < N; i++) begin
        sr[i] <= sr[i-1];
      end
    end
  end

  assign q = sr[N-1];

endmodule

// File: rtl/bre_mulsat.sv
// ----------------------------------------------------------------------------
// bre_mulsat - pipelined signed 64x64 multiply, round and saturate
// Four 32x32 partial products, sum, round half away, shift, clip to 64 bits.
// ----------------------------------------------------------------------------
module bre_mulsat #(
  parameter int SH = 30
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output bre_pkg::sat64_t    p
);

  logic [63:0]  ma, mb;
  logic         neg0, neg1, neg2, neg3;
  logic [63:0]  p00, p01, p10, p11;
  logic [127:0] prod, rnd;

  always_ff @(posedge clk) begin
    if (en) begin
      ma   <= bre_pkg::mag64(a);
      mb   <= bre_pkg::mag64(b);
      neg0 <= a[63] ^ b[63];
      p00  <= ma[31:0] * mb[31:0];
      p01  <= ma[31:0] * mb[63:32];
      p10  <= ma[63:32] * mb[31:0];
      p11  <= ma[63:32] * mb[63:32];
      neg1 <= neg0;
      prod <= {64'd0, p00} + ({64'd0, p01} << 32) + ({64'd0, p10} << 32) + {p11, 64'd0};
      neg2 <= neg1;
      rnd  <= (prod + (128'd1 << (SH - 1))) >> SH;
      neg3 <= neg2;
      p    <= bre_pkg::from_mag(neg3, rnd);
    end
  end

endmodule

// File: rtl/bre_divsat.sv
// ----------------------------------------------------------------------------
// bre_divsat - pipelined (n << 32) / d, round half away, saturate
// One restoring quotient bit per stage on magnitudes.
// ----------------------------------------------------------------------------
module bre_divsat (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] n,
  input  logic signed [63:0] d,
  output bre_pkg::sat64_t    q
);

  localparam int NS = bre_pkg::DIV_STEPS;

  logic [63:0]   dr   [0:NS];
  logic [NS-1:0] dn   [0:NS];
  logic [NS-1:0] dq   [0:NS];
  logic [63:0]   dd   [0:NS];
  logic          dneg [0:NS];
  logic          dnz  [0:NS];
  logic          ddz  [0:NS];

  logic [NS:0]   rq;
  logic          rneg, rnz, rdz;
  logic          up;

  always_ff @(posedge clk) begin
    if (en) begin
      dr[0]   <= '0;
      dn[0]   <= {bre_pkg::mag64(n), 32'd0};
      dq[0]   <= '0;
      dd[0]   <= bre_pkg::mag64(d);
      dneg[0] <= n[63] ^ d[63];
      dnz[0]  <= (n == '0);
      ddz[0]  <= (d == '0);
    end
  end

  for (genvar j = 0; j < NS; j++) begin : g_step
    logic [64:0] trial;
    logic        take;
    assign trial = {dr[j], dn[j][NS-1]};
    assign take  = trial >= {1'b0, dd[j]};
    always_ff @(posedge clk) begin
      if (en) begin
        dr[j+1]   <= take ? 64'(trial - {1'b0, dd[j]}) : trial[63:0];
        dn[j+1]   <= dn[j] << 1;
        dq[j+1]   <= {dq[j][NS-2:0], take};
        dd[j+1]   <= dd[j];
        dneg[j+1] <= dneg[j];
        dnz[j+1]  <= dnz[j];
        ddz[j+1]  <= ddz[j];
      end
    end
  end

  assign up = dr[NS] >= (dd[NS] - dr[NS]);

  always_ff @(posedge clk) begin
    if (en) begin
      rq   <= {1'b0, dq[NS]} + (NS+1)'(up);
      rneg <= dneg[NS];
      rnz  <= dnz[NS];
      rdz  <= ddz[NS];
      if (rnz) begin
        q <= '0;
      end else if (rdz) begin
        q <= bre_pkg::from_mag(rneg, 128'd1 << 64);
      end else begin
        q <= bre_pkg::from_mag(rneg, 128'(rq));
      end
    end
  end

endmodule

// File: rtl/ballistic_rate_evaluator.sv
// Throughput: one word per cycle while the output is not stalled;
// the 96-stage restoring dividers set depth.
// A stall at the output freezes the whole pipe; bubbles are kept, not squeezed.
// Reset clears all valid bits and loads the register defaults
// (gravity 9.81, planet radius 6371000 m, the rest zero).
// ----------------------------------------------------------------------------
// ballistic_rate_evaluator - point-mass trajectory rates
// Reduces angle, CORDIC sin/cos, then saturating products and quotients.
// ----------------------------------------------------------------------------
module ballistic_rate_evaluator #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic [46:0]        speed,
  input  logic signed [47:0] height,
  input  logic signed [18:0] path_angle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [47:0] speed_rate,
  output logic signed [63:0] angle_rate,
  output logic signed [63:0] range_angle_rate,
  output logic signed [47:0] climb_rate,
  output logic               zero_speed,
  output logic               saturated
);

  localparam int AW      = bre_pkg::ANG_W;
  localparam int NC      = bre_pkg::CORDIC_STEPS;
  localparam int ML      = bre_pkg::MUL_LAT;
  localparam int DL      = bre_pkg::DIV_LAT;
  localparam int SHIFT_IN = 30 - FRAC_BITS;
  localparam int ZW      = 19 + SHIFT_IN;
  localparam int MW      = ((ZW > 33) ? ZW : 33) + 1;
  localparam int NMOD    = (FRAC_BITS >= 16) ? 1 : 16 - FRAC_BITS;
  localparam int T0      = 3 + NC + 1;
  localparam int T_NUM   = ML + 1;
  localparam int T_CL    = ML + 1;
  localparam int T_SR    = 2 * ML + 3;
  localparam int T_RR    = ML + DL;
  localparam int T_Q     = T_NUM + DL;
  localparam int T_AR1   = T_Q + 1;
  localparam int LAT     = T0 + T_AR1 + 1;

  localparam logic [46:0] GRAV_RESET = 47'((64'd642908 << FRAC_BITS) >> 16);
  localparam logic [46:0] RAD_RESET  = 47'(64'd6371000 << FRAC_BITS);

  // configuration
  logic signed [47:0] thrust_axial, thrust_normal;
  logic signed [63:0] drag_factor, lift_factor;
  logic [46:0]        gravity, planet_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      thrust_axial  <= '0;
      thrust_normal <= '0;
      drag_factor   <= '0;
      lift_factor   <= '0;
      gravity       <= GRAV_RESET;
      planet_radius <= RAD_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        bre_pkg::REG_THRUST_AXIAL:  thrust_axial  <= $signed(cfg_data[47:0]);
        bre_pkg::REG_THRUST_NORMAL: thrust_normal <= $signed(cfg_data[47:0]);
        bre_pkg::REG_DRAG_FACTOR:   drag_factor   <= $signed(cfg_data);
        bre_pkg::REG_LIFT_FACTOR:   lift_factor   <= $signed(cfg_data);
        bre_pkg::REG_GRAVITY:       gravity       <= cfg_data[46:0];
        bre_pkg::REG_PLANET_RADIUS: planet_radius <= cfg_data[46:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic           adv;
  logic [LAT:1]   vld;

  assign adv       = !vld[LAT] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-1:1], in_valid};
    end
  end

  // stage 1: capture
  logic               p1_rev;
  logic [46:0]        p1_v;
  logic signed [63:0] p1_den;
  logic signed [ZW-1:0] p1_z;

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_rev <= kind;
      p1_v   <= speed;
      p1_den <= $signed({17'd0, planet_radius}) + 64'(height);
      p1_z   <= {path_angle, {SHIFT_IN{1'b0}}};
    end
  end

  // stage 2: remainder by 2*pi, sign of dividend kept
  logic signed [MW-1:0] zx, zr;
  logic [MW-1:0]        zm, tp;
  logic signed [AW-1:0] p2_z;

  always_comb begin
    zx = MW'(p1_z);
    zm = zx[MW-1] ? MW'(-zx) : MW'(zx);
    tp = MW'(bre_pkg::TWO_PI_Q30) << (NMOD - 1);
    for (int k = 0; k < NMOD; k++) begin
      if (zm >= tp) begin
        zm = zm - tp;
      end
      tp = tp >> 1;
    end
    zr = zx[MW-1] ? -$signed(zm) : $signed(zm);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_z <= $signed(zr[AW-1:0]);
    end
  end

  // stage 3: wrap into +-pi, fold into +-pi/2; CORDIC seed
  logic signed [AW-1:0] zw, zf;
  logic                 fold;
  logic signed [AW-1:0] cx [0:NC];
  logic signed [AW-1:0] cy [0:NC];
  logic signed [AW-1:0] cz [0:NC];
  logic                 cflip [0:NC];

  always_comb begin
    if (p2_z > bre_pkg::PI_Q30) begin
      zw = p2_z - bre_pkg::TWO_PI_Q30;
    end else if (p2_z < -bre_pkg::PI_Q30) begin
      zw = p2_z + bre_pkg::TWO_PI_Q30;
    end else begin
      zw = p2_z;
    end
    fold = 1'b1;
    if (zw > bre_pkg::HALF_PI_Q30) begin
      zf = zw - bre_pkg::PI_Q30;
    end else if (zw < -bre_pkg::HALF_PI_Q30) begin
      zf = zw + bre_pkg::PI_Q30;
    end else begin
      zf   = zw;
      fold = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cx[0]    <= bre_pkg::GAIN_Q30;
      cy[0]    <= '0;
      cz[0]    <= zf;
      cflip[0] <= fold;
    end
  end

  for (genvar i = 0; i < NC; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!cz[i][AW-1]) begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - bre_pkg::atan_q30(i);
        end else begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + bre_pkg::atan_q30(i);
        end
        cflip[i+1] <= cflip[i];
      end
    end
  end

  logic signed [AW-1:0] t0_sn, t0_cs;

  always_ff @(posedge clk) begin
    if (adv) begin
      t0_sn <= cflip[NC] ? -cy[NC] : cy[NC];
      t0_cs <= cflip[NC] ? -cx[NC] : cx[NC];
    end
  end

  // side data to the trig output
  logic               t0_rev;
  logic [46:0]        t0_v;
  logic signed [63:0] t0_den;

  bre_dly #(.W(112), .N(T0 - 1)) u_side (
    .clk(clk), .en(adv), .d({p1_rev, p1_v, p1_den}), .q({t0_rev, t0_v, t0_den})
  );

  logic signed [63:0] v64, sn64, cs64, g64, sta, stn;
  logic               vz;

  assign v64  = $signed({17'd0, t0_v});
  assign sn64 = 64'(t0_sn);
  assign cs64 = 64'(t0_cs);
  assign g64  = $signed({17'd0, gravity});
  assign sta  = t0_rev ? -64'(thrust_axial) : 64'(thrust_axial);
  assign stn  = t0_rev ? -64'(thrust_normal) : 64'(thrust_normal);
  assign vz   = (t0_v == '0);

  // products
  bre_pkg::sat64_t dv, dv2, gsn, cl, vc, gcs, lv;
  logic signed [63:0] v_m;

  bre_mulsat #(.SH(32)) u_drag (.clk(clk), .en(adv), .a(drag_factor), .b(v64), .p(dv));
  bre_dly #(.W(64), .N(ML)) u_vm (.clk(clk), .en(adv), .d(v64), .q(v_m));
  bre_mulsat #(.SH(FRAC_BITS)) u_drag2 (.clk(clk), .en(adv), .a(dv.val), .b(v_m), .p(dv2));
  bre_mulsat #(.SH(30)) u_gsn (.clk(clk), .en(adv), .a(g64), .b(sn64), .p(gsn));
  bre_mulsat #(.SH(30)) u_climb (.clk(clk), .en(adv), .a(v64), .b(sn64), .p(cl));
  bre_mulsat #(.SH(30)) u_vc (.clk(clk), .en(adv), .a(v64), .b(cs64), .p(vc));
  bre_mulsat #(.SH(30)) u_gcs (.clk(clk), .en(adv), .a(g64), .b(cs64), .p(gcs));
  bre_mulsat #(.SH(FRAC_BITS)) u_lift (.clk(clk), .en(adv), .a(lift_factor), .b(v64), .p(lv));

  // speed rate
  logic signed [63:0] sta_d;
  logic               dv_sat_d;
  bre_pkg::sat64_t    gsn_d, sub1, sub2, sr1, sr2;
  bre_pkg::sat48_t    c48, sr48, sp_d;

  bre_dly #(.W(64), .N(2 * ML)) u_sta (.clk(clk), .en(adv), .d(sta), .q(sta_d));
  bre_dly #(.W(1), .N(ML)) u_dvs (.clk(clk), .en(adv), .d(dv.sat), .q(dv_sat_d));
  bre_dly #(.W(65), .N(ML + 1)) u_gsnd (.clk(clk), .en(adv), .d(gsn), .q(gsn_d));

  assign sub1 = bre_pkg::sat_sub(sta_d, dv2.val);
  assign sub2 = bre_pkg::sat_sub(sr1.val, gsn_d.val);
  assign c48  = bre_pkg::clamp48(sr2.val);

  always_ff @(posedge clk) begin
    if (adv) begin
      sr1.val  <= sub1.val;
      sr1.sat  <= sub1.sat | dv2.sat | dv_sat_d;
      sr2.val  <= sub2.val;
      sr2.sat  <= sr1.sat | sub2.sat | gsn_d.sat;
      sr48.val <= c48.val;
      sr48.sat <= sr2.sat | c48.sat;
    end
  end

  bre_dly #(.W(49), .N(T_AR1 - T_SR)) u_spd (.clk(clk), .en(adv), .d(sr48), .q(sp_d));

  // climb rate
  bre_pkg::sat48_t cc, cl48, cl_d;

  assign cc = bre_pkg::clamp48(cl.val);

  always_ff @(posedge clk) begin
    if (adv) begin
      cl48.val <= cc.val;
      cl48.sat <= cc.sat | cl.sat;
    end
  end

  bre_dly #(.W(49), .N(T_AR1 - T_CL)) u_cld (.clk(clk), .en(adv), .d(cl48), .q(cl_d));

  // downrange angle rate
  logic signed [63:0] den_m;
  logic               vc_sat_d;
  bre_pkg::sat64_t    rr, rr_f, rr_d;

  bre_dly #(.W(64), .N(ML)) u_denm (.clk(clk), .en(adv), .d(t0_den), .q(den_m));
  bre_divsat u_rr (.clk(clk), .en(adv), .n(vc.val), .d(den_m), .q(rr));
  bre_dly #(.W(1), .N(DL)) u_vcs (.clk(clk), .en(adv), .d(vc.sat), .q(vc_sat_d));

  assign rr_f = '{sat: rr.sat | vc_sat_d, val: rr.val};

  bre_dly #(.W(65), .N(T_AR1 - T_RR)) u_rrd (.clk(clk), .en(adv), .d(rr_f), .q(rr_d));

  // path angle rate
  logic signed [63:0] stn_m, v_n;
  logic               num_f_d, vz_d;
  bre_pkg::sat64_t    nsub, num, q, lv_d, a1, ar1, a2;

  bre_dly #(.W(64), .N(ML)) u_stn (.clk(clk), .en(adv), .d(stn), .q(stn_m));

  assign nsub = bre_pkg::sat_sub(stn_m, gcs.val);

  always_ff @(posedge clk) begin
    if (adv) begin
      num.val <= nsub.val;
      num.sat <= nsub.sat | gcs.sat;
    end
  end

  bre_dly #(.W(64), .N(T_NUM)) u_vn (.clk(clk), .en(adv), .d(v64), .q(v_n));
  bre_divsat u_q (.clk(clk), .en(adv), .n(num.val), .d(v_n), .q(q));
  bre_dly #(.W(1), .N(DL)) u_nfd (.clk(clk), .en(adv), .d(num.sat), .q(num_f_d));
  bre_dly #(.W(65), .N(T_Q - ML)) u_lvd (.clk(clk), .en(adv), .d(lv), .q(lv_d));
  bre_dly #(.W(1), .N(T_AR1)) u_vzd (.clk(clk), .en(adv), .d(vz), .q(vz_d));

  assign a1 = bre_pkg::sat_add(q.val, lv_d.val);
  assign a2 = bre_pkg::sat_add(ar1.val, rr_d.val);

  always_ff @(posedge clk) begin
    if (adv) begin
      ar1.val <= a1.val;
      ar1.sat <= a1.sat | q.sat | num_f_d | lv_d.sat;
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (adv) begin
      speed_rate       <= sp_d.val;
      angle_rate       <= vz_d ? '0 : a2.val;
      range_angle_rate <= rr_d.val;
      climb_rate       <= cl_d.val;
      zero_speed       <= vz_d;
      saturated        <= sp_d.sat | cl_d.sat | rr_d.sat | (!vz_d & (ar1.sat | a2.sat));
    end
  end

`ifndef NO_ASSERTIONS
  ast_zero_angle: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_speed |-> angle_rate == '0)
    else $error("angle rate not cleared at zero speed");

  ast_zero_terms: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_speed |-> range_angle_rate == '0 && climb_rate == '0)
    else $error("nonzero range or climb rate at zero speed");

  ast_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("valid pipe moved during stall");

  ast_fold_range: assert property (@(posedge clk) disable iff (rst)
    vld[3] |-> cz[0] <= bre_pkg::HALF_PI_Q30 && cz[0] >= -bre_pkg::HALF_PI_Q30)
    else $error("folded angle outside half pi");
`endif

endmodule

// File: test/tb_ballistic_rate_evaluator.sv
// ----------------------------------------------------------------------------
// tb_ballistic_rate_evaluator - trajectory rate evaluator testbench
// Drives state words through the valid/ready input with random gaps, stalls the
// result side at random, predicts every rate word in fixed point with its own
// CORDIC and saturating math, and checks results in order across several
// register settings, including the extremes.
// ----------------------------------------------------------------------------
module tb_ballistic_rate_evaluator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam int SETTLE = 160;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PER_PHASE = 230;
  localparam longint S64_TOP = 64'sh7fff_ffff_ffff_ffff;
  localparam longint S64_BOT = 64'sh8000_0000_0000_0000;

  typedef struct {
    logic signed [47:0] speed_rate;
    logic signed [63:0] angle_rate;
    logic signed [63:0] range_rate;
    logic signed [47:0] climb_rate;
    logic               zero_speed;
    logic               saturated;
  } rates_t;

  class rate_checker;
    rates_t pending_rates[$];
    int errors;
    logic [63:0] regs[6];
    longint atan_tab[30];

    function new();
      atan_tab = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                   16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
                   131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
                   128, 64, 32, 16, 8, 4, 2};
      regs = '{64'd0, 64'd0, 64'd0, 64'd0, 64'd642908, 64'd417529856000};
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] val);
      case (idx)
        bre_pkg::REG_THRUST_AXIAL, bre_pkg::REG_THRUST_NORMAL:
          regs[idx] = val & 64'hffff_ffff_ffff;
        bre_pkg::REG_DRAG_FACTOR, bre_pkg::REG_LIFT_FACTOR:
          regs[idx] = val;
        bre_pkg::REG_GRAVITY, bre_pkg::REG_PLANET_RADIUS:
          regs[idx] = val & 64'h7fff_ffff_ffff;
        default: ;
      endcase
    endfunction

    function logic [63:0] magn(longint a);
      return a < 0 ? 64'd0 - 64'(a) : 64'(a);
    endfunction

    function longint clip_mag(bit neg, logic [127:0] m, inout bit sat);
      if (neg) begin
        if (m > 128'h8000_0000_0000_0000) begin
          sat = 1;
          return S64_BOT;
        end
        return longint'(64'd0 - m[63:0]);
      end
      if (m > 128'h7fff_ffff_ffff_ffff) begin
        sat = 1;
        return S64_TOP;
      end
      return longint'(m[63:0]);
    endfunction

    function longint mul_round(longint a, longint b, int sh, inout bit sat);
      logic [127:0] p;
      p = {64'd0, magn(a)} * {64'd0, magn(b)};
      if (sh > 0) p = (p + (128'd1 << (sh - 1))) >> sh;
      return clip_mag((a < 0) != (b < 0), p, sat);
    endfunction

    function longint div_round(longint n, longint d, inout bit sat);
      logic [127:0] num, den, q, r;
      bit neg;
      neg = (n < 0) != (d < 0);
      num = {64'd0, magn(n)} << 32;
      den = {64'd0, magn(d)};
      if (num == 0) return 0;
      if (den == 0) return clip_mag(neg, 128'd1 << 64, sat);
      q = num / den;
      r = num % den;
      if (r >= den - r) q = q + 1;
      return clip_mag(neg, q, sat);
    endfunction

    function longint add_sat(longint a, longint b, inout bit sat);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) begin
        sat = 1;
        return s[64] ? S64_BOT : S64_TOP;
      end
      return s[63:0];
    endfunction

    function longint sub_sat(longint a, longint b, inout bit sat);
      logic signed [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s[64] != s[63]) begin
        sat = 1;
        return s[64] ? S64_BOT : S64_TOP;
      end
      return s[63:0];
    endfunction

    function logic signed [47:0] fit48(longint v, inout bit sat);
      if (v > 64'sh7fff_ffff_ffff) begin
        sat = 1;
        return 48'sh7fff_ffff_ffff;
      end
      if (v < -64'sh8000_0000_0000) begin
        sat = 1;
        return 48'sh8000_0000_0000;
      end
      return v[47:0];
    endfunction

    function void sin_cos(longint ang, output longint sn, output longint cs);
      longint z, x, y, t;
      bit flip;
      z = (ang * (64'sd1 <<< (30 - FRAC))) % longint'(bre_pkg::TWO_PI_Q30);
      x = longint'(bre_pkg::GAIN_Q30);
      y = 0;
      flip = 0;
      if (z > longint'(bre_pkg::PI_Q30)) z -= longint'(bre_pkg::TWO_PI_Q30);
      if (z < -longint'(bre_pkg::PI_Q30)) z += longint'(bre_pkg::TWO_PI_Q30);
      if (z > longint'(bre_pkg::HALF_PI_Q30)) begin
        z -= longint'(bre_pkg::PI_Q30);
        flip = 1;
      end else if (z < -longint'(bre_pkg::HALF_PI_Q30)) begin
        z += longint'(bre_pkg::PI_Q30);
        flip = 1;
      end
      for (int i = 0; i < 30; i++) begin
        if (z >= 0) begin
          t = x - (y >>> i);
          y = y + (x >>> i);
          z -= atan_tab[i];
        end else begin
          t = x + (y >>> i);
          y = y - (x >>> i);
          z += atan_tab[i];
        end
        x = t;
      end
      sn = flip ? -y : y;
      cs = flip ? -x : x;
    endfunction

    function void note(bit k, logic [46:0] sp, logic signed [47:0] h,
                       logic signed [18:0] a);
      rates_t e;
      bit sat;
      longint ta, tn, drag, lift, g, rad, v, sn, cs, sr, vc, rr, ar, num;
      sat = 0;
      ta = longint'($signed(regs[0][47:0]));
      tn = longint'($signed(regs[1][47:0]));
      drag = longint'(regs[2]);
      lift = longint'(regs[3]);
      g = longint'(regs[4]);
      rad = longint'(regs[5]);
      v = longint'({17'd0, sp});
      if (k) begin
        ta = -ta;
        tn = -tn;
      end
      sin_cos(longint'(a), sn, cs);
      sr = mul_round(mul_round(drag, v, 32, sat), v, FRAC, sat);
      sr = sub_sat(sub_sat(ta, sr, sat), mul_round(g, sn, 30, sat), sat);
      e.speed_rate = fit48(sr, sat);
      e.climb_rate = fit48(mul_round(v, sn, 30, sat), sat);
      vc = mul_round(v, cs, 30, sat);
      rr = div_round(vc, rad + longint'(h), sat);
      e.zero_speed = (v == 0);
      if (v == 0) ar = 0;
      else begin
        num = sub_sat(tn, mul_round(g, cs, 30, sat), sat);
        ar = add_sat(div_round(num, v, sat), mul_round(lift, v, FRAC, sat), sat);
        ar = add_sat(ar, rr, sat);
      end
      e.angle_rate = ar;
      e.range_rate = rr;
      e.saturated = sat;
      pending_rates.push_back(e);
    endfunction

    function void report(string field, logic [63:0] want, logic [63:0] got);
      errors++;
      if (errors <= 10)
        $display("mismatch %s: expected %h got %h at %0t", field, want, got, $time);
    endfunction

    function void check(rates_t got);
      rates_t e;
      if (pending_rates.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word at %0t", $time);
        return;
      end
      e = pending_rates.pop_front();
      if (got.speed_rate !== e.speed_rate) report("speed_rate", e.speed_rate, got.speed_rate);
      if (got.angle_rate !== e.angle_rate) report("angle_rate", e.angle_rate, got.angle_rate);
      if (got.range_rate !== e.range_rate)
        report("range_angle_rate", e.range_rate, got.range_rate);
      if (got.climb_rate !== e.climb_rate) report("climb_rate", e.climb_rate, got.climb_rate);
      if (got.zero_speed !== e.zero_speed) report("zero_speed", e.zero_speed, got.zero_speed);
      if (got.saturated !== e.saturated) report("saturated", e.saturated, got.saturated);
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_write = 0;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic kind = 0;
  logic [46:0] speed = '0;
  logic signed [47:0] height = '0;
  logic signed [18:0] path_angle = '0;
  logic out_valid;
  logic out_ready = 1;
  logic signed [47:0] speed_rate;
  logic signed [63:0] angle_rate;
  logic signed [63:0] range_angle_rate;
  logic signed [47:0] climb_rate;
  logic zero_speed;
  logic saturated;

  rate_checker board = new();
  bit steady = 0;
  int idle_cycles = 0;

  ballistic_rate_evaluator uut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    rates_t got;
    if (!rst && out_valid && out_ready) begin
      got.speed_rate = speed_rate;
      got.angle_rate = angle_rate;
      got.range_rate = range_angle_rate;
      got.climb_rate = climb_rate;
      got.zero_speed = zero_speed;
      got.saturated = saturated;
      board.check(got);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("tb_ballistic_rate_evaluator: done, errors");
      $finish;
    end
  end

  initial begin
    int n;
    @(negedge rst);
    forever begin
      do @(posedge clk); while (!(out_valid && out_ready));
      n = steady ? 0 : $urandom_range(0, 18);
      if (n > 0) begin
        out_ready <= 0;
        repeat (n) @(posedge clk);
        out_ready <= 1;
      end
    end
  end

  task automatic load_regs(input logic [63:0] vals[6]);
    for (int i = 0; i < 8; i++) begin
      cfg_write <= 1;
      cfg_index <= i[2:0];
      cfg_data <= (i < 6) ? vals[i] : {$urandom, $urandom};
      if (i < 6) board.set_reg(i[2:0], vals[i]);
      @(posedge clk);
    end
    cfg_write <= 0;
  endtask

  task automatic push_word(bit k, logic [46:0] sp, logic [47:0] h, logic [18:0] a);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    kind <= k;
    speed <= sp;
    height <= h;
    path_angle <= a;
    do @(posedge clk); while (!in_ready);
    board.note(k, sp, h, a);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending_rates.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic push_directed();
    logic [47:0] rad;
    rad = board.regs[5][47:0];
    push_word(0, 47'd0, 48'd0, 19'd0);
    push_word(1, 47'd0, 48'sd655360000, 19'sd102944);
    push_word(0, 47'd1, 48'd0, 19'sd205887);
    push_word(1, 47'd1, 48'd0, -19'sd205887);
    push_word(0, {47{1'b1}}, {1'b0, {47{1'b1}}}, 19'sd102944);
    push_word(1, {47{1'b1}}, {1'b1, 47'd0}, -19'sd102944);
    push_word(0, 47'd7000 << 16, 48'd0 - rad, 19'd0);
    push_word(1, 47'd7000 << 16, 48'd0 - rad, 19'sd51472);
    push_word(0, 47'd300 << 16, 48'd0 - rad - 48'd65536, 19'sd30000);
    push_word(0, 47'd2000 << 16, 48'd0, 19'h3ffff);
    push_word(1, 47'd2000 << 16, 48'd0, 19'h40000);
    push_word(0, 47'd2000 << 16, 48'd0, 19'sd210000);
    push_word(1, 47'd50 << 16, 48'sd6553600, -19'sd250000);
    push_word(0, 47'h2aaa_aaaa_aaaa, 48'h5555_5555_5555, 19'h2aaaa);
    push_word(1, 47'h5555_5555_5555, 48'haaaa_aaaa_aaaa, 19'h55555);
    push_word(0, 47'd1 << 16, 48'd1 << 16, 19'sd1);
  endtask

  task automatic push_random();
    logic [46:0] sp;
    logic [47:0] h;
    logic [18:0] a;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      sp = (47'($urandom_range(0, 9000)) << 16) | 47'($urandom_range(0, 65535));
      h = (48'($urandom_range(0, 300000)) << 16) | 48'($urandom_range(0, 65535));
      a = 19'($signed($urandom_range(0, 411774)) - 205887);
    end else begin
      sp = 47'({$urandom, $urandom});
      h = 48'({$urandom, $urandom});
      a = 19'($urandom);
    end
    if (pick < 3) sp = 0;
    push_word($urandom_range(0, 1), sp, h, a);
  endtask

  initial begin
    logic [63:0] sets[7][6];
    sets[0] = '{64'd0, 64'd0, 64'd0, 64'd0, 64'd642908, 64'd417529856000};
    sets[1] = '{64'd20 << 16, 64'd1 << 16, 64'd42950, 64'd4295, 64'd642908,
                64'd417529856000};
    sets[2] = '{64'h7fff_ffff_ffff, 64'h8000_0000_0000, 64'h7fff_ffff_ffff_ffff,
                64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff, 64'h7fff_ffff_ffff};
    sets[3] = '{64'd0, 64'd0, 64'd0, 64'd0, 64'd0, 64'd0};
    sets[4] = '{64'h8000_0000_0000, 64'h7fff_ffff_ffff, 64'h8000_0000_0000_0000,
                64'h7fff_ffff_ffff_ffff, 64'd0, 64'd1};
    sets[5] = '{{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom}};
    sets[6] = '{64'hffff_fffe_0000, 64'd3 << 16, 64'h0000_0000_0001_0000,
                64'hffff_ffff_ffff_0000, 64'd162 << 16, 64'd3390000 << 16};
    repeat (6) @(posedge clk);
    rst <= 0;
    for (int p = 0; p < 7; p++) begin
      if (p > 0) load_regs(sets[p]);
      if (p == 1 || p == 2) push_directed();
      for (int i = 0; i < PER_PHASE; i++) begin
        if (i % 40 == 0) steady = ($urandom_range(0, 3) == 0);
        push_random();
      end
      steady = 0;
      drain();
    end
    if (board.errors == 0 && board.pending_rates.size() == 0)
      $display("tb_ballistic_rate_evaluator: done, clean");
    else
      $display("tb_ballistic_rate_evaluator: done, errors");
    $finish;
  end

endmodule
